// ----- src/indexed_list_buffer_unit_assert.svh -----
// assertion macros shared by the list buffer rtl
`ifndef INDEXED_LIST_BUFFER_UNIT_ASSERT_SVH
`define INDEXED_LIST_BUFFER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ILB_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ILB_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/ilb_pkg.sv -----
package ilb_pkg;

    // default sizing
    localparam int ILB_CAPACITY  = 64;
    localparam int ILB_WORD_BITS = 32;

    // fixed field widths
    localparam int OPCODE_BITS   = 3;
    localparam int POS_BITS      = 7;
    localparam int IO_WORD_BITS  = 32;
    localparam int COUNT_BITS    = 7;
    localparam int STATUS_BITS   = 2;

    // opcodes
    localparam logic [OPCODE_BITS-1:0] OP_APPEND    = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_DROP_LAST = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_READ      = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_OVERWRITE = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_INSERT    = 3'd4;
    localparam logic [OPCODE_BITS-1:0] OP_REMOVE_AT = 3'd5;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR     = 3'd6;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd2;

endpackage

// ----- src/ilb_ram.sv -----
module ilb_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/indexed_list_buffer_unit.sv -----
// Ordered list of up to CAPACITY signed words kept in one single-port-write,
// one-port-read synchronous RAM with a registered read. Each input transaction
// carries one opcode (append, drop last, read, overwrite, insert, remove at,
// clear) and produces exactly one result transaction with the value read, the
// entry count after the operation and a status (ok, position out of range,
// list full); a rejected operation leaves the list untouched. One operation is
// in flight at a time. Append, drop last, read, overwrite, clear, any rejected
// operation, an insert at the end and a remove of the last entry go straight to
// the done state. Insert at p moves entries count - 1 down to p up a place in
// the shift-up state, then writes the word; remove at p moves entries p + 1 to
// count - 1 down a place in the shift-down state. The RAM moves one entry per
// cycle (read of the neighbor overlapped with write of the previous move). A
// finished result sits in the output register, so the next transaction can be
// accepted while the previous result still waits. Stored entries are not
// cleared at reset; only entries below the count are ever read.
`include "indexed_list_buffer_unit_assert.svh"

module indexed_list_buffer_unit
    import ilb_pkg::*;
#(
    parameter int CAPACITY  = ILB_CAPACITY,
    parameter int WORD_BITS = ILB_WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [OPCODE_BITS-1:0]         s_opcode,
    input  logic [POS_BITS-1:0]            s_position,
    input  logic signed [IO_WORD_BITS-1:0] s_word_in,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [IO_WORD_BITS-1:0] m_read_value,
    output logic [COUNT_BITS-1:0]          m_entry_count,
    output logic [STATUS_BITS-1:0]         m_status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // common width for position versus count compares, with headroom for +1 / +2
    localparam int XW = ((CW > POS_BITS) ? CW : POS_BITS) + 2;
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SHIFT_UP = 3'd1;
    localparam logic [2:0] ST_INS_WR   = 3'd2;
    localparam logic [2:0] ST_SHIFT_DN = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    // control state
    logic [2:0]                     state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic                           m_valid_reg, m_valid_next;

    // transaction context held while the operation runs
    logic [OPCODE_BITS-1:0]         op_reg, op_next;
    logic [STATUS_BITS-1:0]         status_reg, status_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    logic [WORD_BITS-1:0]           word_reg, word_next;
    logic [AW-1:0]                  ptr_reg, ptr_next;

    // output payload
    logic signed [IO_WORD_BITS-1:0] m_read_value_reg, m_read_value_next;
    logic [COUNT_BITS-1:0]          m_entry_count_reg, m_entry_count_next;
    logic [STATUS_BITS-1:0]         m_status_reg, m_status_next;

    // ram access
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [WORD_BITS-1:0]           wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [WORD_BITS-1:0]           rd_data;

    // decode helpers
    logic [XW-1:0]                  pos_x;
    logic [XW-1:0]                  cnt_x;
    logic [AW-1:0]                  pos_addr;
    logic [AW-1:0]                  cnt_addr;
    logic [WORD_BITS-1:0]           word_store;
    logic                           count_full;

    ilb_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (WORD_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pos_x      = XW'(s_position);
    assign cnt_x      = XW'(count_reg);
    // only used once the position is known to be below capacity
    assign pos_addr   = AW'(s_position);
    assign cnt_addr   = AW'(count_reg);
    // word kept in its low WORD_BITS bits, upper bits zero when wider
    assign word_store = WORD_BITS'($unsigned(s_word_in));
    assign count_full = (count_reg == CAP_COUNT);

    // accept only when no operation is in flight
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next         = state_reg;
        count_next         = count_reg;
        m_valid_next       = m_valid_reg;
        op_next            = op_reg;
        status_next        = status_reg;
        pos_next           = pos_reg;
        word_next          = word_reg;
        ptr_next           = ptr_reg;
        m_read_value_next  = m_read_value_reg;
        m_entry_count_next = m_entry_count_reg;
        m_status_next      = m_status_reg;
        wr_en              = 1'b0;
        wr_addr            = pos_reg;
        wr_data            = word_reg;
        rd_en              = 1'b0;
        rd_addr            = pos_reg;

        // result taken downstream
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_opcode;
                    pos_next    = pos_addr;
                    word_next   = word_store;
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                    case (s_opcode)
                        OP_APPEND: begin
                            if (count_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = cnt_addr;
                                wr_data    = word_store;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DROP_LAST: begin
                            // empty list: nothing to drop, still ok
                            if (count_reg != '0) begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (pos_x >= cnt_x) begin
                                status_next = STAT_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = pos_addr;
                            end
                        end
                        OP_OVERWRITE: begin
                            if (pos_x >= cnt_x) begin
                                status_next = STAT_RANGE;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = pos_addr;
                                wr_data = word_store;
                            end
                        end
                        OP_INSERT: begin
                            // range check ranks above the full check
                            if (pos_x > cnt_x) begin
                                status_next = STAT_RANGE;
                            end else if (count_full) begin
                                status_next = STAT_FULL;
                            end else if (pos_x == cnt_x) begin
                                wr_en      = 1'b1;
                                wr_addr    = pos_addr;
                                wr_data    = word_store;
                                count_next = count_reg + 1'b1;
                            end else begin
                                // move the top entry up first
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_reg - 1'b1);
                                ptr_next   = cnt_addr;
                                state_next = ST_SHIFT_UP;
                            end
                        end
                        OP_REMOVE_AT: begin
                            if (pos_x >= cnt_x) begin
                                status_next = STAT_RANGE;
                            end else if ((pos_x + XW'(1)) == cnt_x) begin
                                count_next = count_reg - 1'b1;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_addr + 1'b1;
                                ptr_next   = pos_addr;
                                state_next = ST_SHIFT_DN;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            // unused opcode: no change, ok status
                        end
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                // rd_data holds entry ptr-1, moves to ptr
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data;
                if ((ptr_reg - 1'b1) == pos_reg) begin
                    state_next = ST_INS_WR;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - AW'(2);
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            ST_INS_WR: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = word_reg;
                count_next = count_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_SHIFT_DN: begin
                // rd_data holds entry ptr+1, moves to ptr
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_data;
                if ((XW'(ptr_reg) + XW'(2)) == cnt_x) begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + AW'(2);
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if ((op_reg == OP_READ) && (status_reg == STAT_OK)) begin
                        m_read_value_next = IO_WORD_BITS'($signed(rd_data));
                    end else begin
                        m_read_value_next = '0;
                    end
                    m_entry_count_next = COUNT_BITS'(count_reg);
                    m_status_next      = status_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        op_reg            <= op_next;
        status_reg        <= status_next;
        pos_reg           <= pos_next;
        word_reg          <= word_next;
        ptr_reg           <= ptr_next;
        m_read_value_reg  <= m_read_value_next;
        m_entry_count_reg <= m_entry_count_next;
        m_status_reg      <= m_status_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_status      = m_status_reg;

    // count stays within capacity
    `ILB_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CAP_COUNT,
        "entry count above capacity")
    // a move never reads the entry it writes in the same cycle
    `ILB_ASSERT_NOW(a_no_rw_clash, aclk, aresetn, wr_en && rd_en, wr_addr != rd_addr,
        "ram read and write hit the same entry")
    // count holds while entries move up
    `ILB_ASSERT_NEXT(a_shift_count, aclk, aresetn, state_reg == ST_SHIFT_UP,
        count_reg == $past(count_reg), "count changed during shift up")
    // a finished operation with a free output register shows a result next cycle
    `ILB_ASSERT_NEXT(a_done_loads, aclk, aresetn,
        (state_reg == ST_DONE) && (!m_valid_reg || m_ready),
        m_valid_reg && (state_reg == ST_IDLE), "result not loaded from done")

endmodule
